[rtl/csl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the cache set
// Field widths, register indexes and the control word that the top level
// hands to every cell of the tag chain.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int TagW    = 20;
  localparam int PosW    = 3;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLICY_FIFO     = 2'd0,
    CFG_WRITE_BACK_MODE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic acc;
    logic miss;
    logic lru;
    logic mark;
  } csl_ctrl_t;

endpackage
`default_nettype wire

[rtl/csl_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csl_cell: one position of the ordered tag list
// Holds a tag and its dirty mark, compares the tag with the access, and
// either takes the entry of its front neighbor or keeps its own, marking it dirty on a marked hit.
// ----------------------------------------------------------------------------
module csl_cell #(
  parameter int TAG_BITS = 20
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  csl_pkg::csl_ctrl_t   ctrl,
  input  wire                  valid_i,
  input  wire  [TAG_BITS-1:0]  key,
  input  wire  [TAG_BITS-1:0]  prev_tag,
  input  wire                  prev_dirty,
  input  wire                  found_in,
  output logic [TAG_BITS-1:0]  tag_q,
  output logic                 dirty_q,
  output logic                 match,
  output logic                 found_out
);
  import csl_pkg::*;

  logic [TAG_BITS-1:0] tag_r;
  logic                dirty_r;
  logic                shift;

  assign match     = valid_i && (tag_r == key);
  assign found_out = found_in || match;
  assign shift     = ctrl.acc && (ctrl.miss || (ctrl.lru && !found_in));
  assign tag_q     = tag_r;
  assign dirty_q   = dirty_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      tag_r <= prev_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b0;
    end else if (shift) begin
      dirty_r <= prev_dirty;
    end else if (ctrl.acc && match && ctrl.mark) begin
      dirty_r <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/cache_set_lru_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cache_set_lru_fifo: one cache set with LRU or FIFO replacement
// A chain of cells keeps the tags in list order; every access is compared
// with all cells at once, and a miss shifts the list one position toward the tail.
//
//   channel  ports                                   direction
//   in       in_valid/in_ready, in_tag, in_is_write  word into the set
//   out      out_valid/out_ready, out_hit, ...       result word
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data register write
//
// An access is looked up and the list updated in the cycle it is accepted.
// Its result word stands in the output register from the next cycle on.
// Throughput is one word per cycle while the output is not stalled.
// After reset the set is empty; no clearing pass is needed.
// A stalled output holds its word, and input is refused only while it waits.
// ----------------------------------------------------------------------------
module cache_set_lru_fifo #(
  parameter int WAYS     = 8,
  parameter int TAG_BITS = 20
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [csl_pkg::TagW-1:0]       in_tag,
  input  wire                            in_is_write,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_hit,
  output logic [csl_pkg::PosW-1:0]       out_hit_position,
  output logic                           out_evicted,
  output logic [csl_pkg::TagW-1:0]       out_evicted_tag,
  output logic                           out_writeback,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [csl_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire                            cfg_data
);
  import csl_pkg::*;

  localparam int OccW = $clog2(WAYS + 1);
  localparam int IdxW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AccW = (IdxW > PosW) ? IdxW : PosW;

  logic                policy_fifo_r;
  logic                write_back_mode_r;
  logic [OccW-1:0]     occ_r;
  logic [OccW-1:0]     occ_nxt;

  logic                out_valid_r;
  logic                out_hit_r;
  logic [PosW-1:0]     out_hit_position_r;
  logic                out_evicted_r;
  logic [TagW-1:0]     out_evicted_tag_r;
  logic                out_writeback_r;

  logic                acc;
  logic [TAG_BITS-1:0] key;
  logic                mark;
  logic                hit;
  logic                full;
  logic                hit_dirty;
  logic                front_dirty;
  logic [AccW-1:0]     pos;
  csl_ctrl_t           ctrl;

  logic [TAG_BITS-1:0] tags  [WAYS];
  logic [WAYS-1:0]     dirty;
  logic [WAYS-1:0]     match;
  logic [WAYS:0]       found;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign key       = TAG_BITS'(in_tag);
  assign mark      = in_is_write && write_back_mode_r;
  assign full      = (occ_r == OccW'(WAYS));
  assign hit       = found[WAYS];
  assign hit_dirty = |(match & dirty);
  assign front_dirty = hit ? (hit_dirty || mark) : mark;
  assign found[0]  = 1'b0;

  assign ctrl.acc  = acc;
  assign ctrl.miss = !hit;
  assign ctrl.lru  = !policy_fifo_r;
  assign ctrl.mark = mark;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    logic [TAG_BITS-1:0] prev_tag;
    logic                prev_dirty;
    if (i == 0) begin : g_front
      assign prev_tag   = key;
      assign prev_dirty = front_dirty;
    end else begin : g_link
      assign prev_tag   = tags[i-1];
      assign prev_dirty = dirty[i-1];
    end
    csl_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .valid_i    (occ_r > OccW'(i)),
      .key        (key),
      .prev_tag   (prev_tag),
      .prev_dirty (prev_dirty),
      .found_in   (found[i]),
      .tag_q      (tags[i]),
      .dirty_q    (dirty[i]),
      .match      (match[i]),
      .found_out  (found[i+1])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (match[i]) begin
        pos = pos | AccW'(i);
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (acc && !hit && !full) begin
      occ_nxt = occ_r + OccW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_fifo_r     <= 1'b0;
      write_back_mode_r <= 1'b1;
      occ_r             <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_POLICY_FIFO) begin
          policy_fifo_r <= cfg_data;
        end else if (cfg_index == CFG_WRITE_BACK_MODE) begin
          write_back_mode_r <= cfg_data;
        end
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_hit_r          <= hit;
      out_hit_position_r <= hit ? pos[PosW-1:0] : '0;
      out_evicted_r      <= !hit && full;
      out_evicted_tag_r  <= (!hit && full) ? TagW'(tags[WAYS-1]) : '0;
      out_writeback_r    <= !hit && full && dirty[WAYS-1] && write_back_mode_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_position = out_hit_position_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_tag  = out_evicted_tag_r;
  assign out_writeback    = out_writeback_r;

  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OccW'(WAYS))
    else $error("occupancy exceeds the number of ways");

  a_one_match : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("tag present in more than one way");

  a_fill : assert property (@(posedge clk) disable iff (!rst_n)
    acc && !hit && !full |=> occ_r == $past(occ_r) + OccW'(1))
    else $error("miss on a set with room did not add an entry");

  a_evict_miss : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evicted_r |-> !out_hit_r)
    else $error("eviction reported on a hit");

  a_wb_evict : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_writeback_r |-> out_evicted_r)
    else $error("writeback without an eviction");

endmodule
`default_nettype wire
